@@ design/sif_pkg.sv @@
// Shared constants for the segment intersection finder: configuration register map.
`timescale 1ns / 1ps

package sif_pkg;

    // Configuration register map
    localparam int CFG_NUM    = 4;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_START_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_X  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_Y  = 2'd3;

endpackage

@@ design/sif_div_pipe.sv @@
// Pipelined restoring divider: two numerators over one shared divisor, one quotient bit a stage.
`timescale 1ns / 1ps

module sif_div_pipe #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 34,
    parameter int QUO_W = 16,
    parameter int TAG_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num_x,
    input  logic [NUM_W-1:0] i_num_y,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo_x,
    output logic [QUO_W-1:0] o_quo_y,
    output logic [TAG_W-1:0] o_tag
);

    // Stage registers, one entry per quotient bit
    logic             r_v     [QUO_W];
    logic [NUM_W-1:0] r_rem_x [QUO_W];
    logic [NUM_W-1:0] r_rem_y [QUO_W];
    logic [QUO_W-1:0] r_q_x   [QUO_W];
    logic [QUO_W-1:0] r_q_y   [QUO_W];
    logic [DEN_W-1:0] r_den   [QUO_W];
    logic [TAG_W-1:0] r_tag   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic             src_v;
        logic [NUM_W-1:0] src_rem_x;
        logic [NUM_W-1:0] src_rem_y;
        logic [QUO_W-1:0] src_q_x;
        logic [QUO_W-1:0] src_q_y;
        logic [DEN_W-1:0] src_den;
        logic [TAG_W-1:0] src_tag;
        logic [NUM_W-1:0] den_sh;
        logic [NUM_W:0]   diff_x;
        logic [NUM_W:0]   diff_y;
        logic [NUM_W-1:0] n_rem_x;
        logic [NUM_W-1:0] n_rem_y;
        logic [QUO_W-1:0] n_q_x;
        logic [QUO_W-1:0] n_q_y;

        // Pick the previous stage, or the ports for the first one
        if (k == 0) begin : g_first
            assign src_v     = i_valid;
            assign src_rem_x = i_num_x;
            assign src_rem_y = i_num_y;
            assign src_q_x   = '0;
            assign src_q_y   = '0;
            assign src_den   = i_den;
            assign src_tag   = i_tag;
        end else begin : g_next
            assign src_v     = r_v[k-1];
            assign src_rem_x = r_rem_x[k-1];
            assign src_rem_y = r_rem_y[k-1];
            assign src_q_x   = r_q_x[k-1];
            assign src_q_y   = r_q_y[k-1];
            assign src_den   = r_den[k-1];
            assign src_tag   = r_tag[k-1];
        end

        // Trial subtract of the shifted divisor; keep it when no borrow
        always_comb begin
            den_sh  = NUM_W'(src_den) << BIT;
            diff_x  = {1'b0, src_rem_x} - {1'b0, den_sh};
            diff_y  = {1'b0, src_rem_y} - {1'b0, den_sh};
            n_rem_x = diff_x[NUM_W] ? src_rem_x : diff_x[NUM_W-1:0];
            n_rem_y = diff_y[NUM_W] ? src_rem_y : diff_y[NUM_W-1:0];
            n_q_x   = src_q_x;
            n_q_y   = src_q_y;
            n_q_x[BIT] = !diff_x[NUM_W];
            n_q_y[BIT] = !diff_y[NUM_W];
        end

        // Advance the stage when the pipeline moves
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= src_v;
            end
            if (i_en) begin
                r_rem_x[k] <= n_rem_x;
                r_rem_y[k] <= n_rem_y;
                r_q_x[k]   <= n_q_x;
                r_q_y[k]   <= n_q_y;
                r_den[k]   <= src_den;
                r_tag[k]   <= src_tag;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo_x = r_q_x[QUO_W-1];
    assign o_quo_y = r_q_y[QUO_W-1];
    assign o_tag   = r_tag[QUO_W-1];

endmodule

@@ design/segment_intersection_finder.sv @@
// Top level of the segment intersection finder: stream pipeline, config registers, output buffer.
//
// Usage: write the query start and goal points through the config port (index 0 start x,
// 1 start y, 2 goal x, 3 goal y) while no item is in flight. Obstacle segments then stream
// in on the s_axis channel, one item per cycle while s_axis_tready is high. For every segment
// that crosses the query segment (non-parallel, both line parameters in [0,1]) an item with
// the segment index and the intersection point comes out on m_axis; misses, parallel or
// collinear segments and hits whose truncated offset from the start point is zero give no
// item. Items keep their input order. From acceptance an item passes the difference, product,
// sum, compare and scale stages, the divider, which retires one quotient bit per stage, and
// the output register. Throughput: one item per cycle while s_axis_tready is high.
// Reset: synchronous, active low; clears the config registers to zero and drops all
// items in flight.
// Stall: an output register and a one-entry skid buffer sit behind the pipeline. While
// the receiver stalls the pipeline keeps accepting until the skid entry fills, then
// s_axis_tready drops and the whole pipeline holds; nothing is lost or repeated.
`timescale 1ns / 1ps

module segment_intersection_finder #(
    parameter  int MAX_LINES   = 1024,
    parameter  int COORD_WIDTH = 16,
    localparam int IW          = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1,
    localparam int IN_W        = IW + 4 * COORD_WIDTH,
    localparam int IN_TDW      = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = IW + 2 * COORD_WIDTH,
    localparam int OUT_TDW     = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sif_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]        i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // line_index, seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero fill
    input  logic [IN_TDW-1:0]             s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit_index, hit_x, hit_y, zero fill
    output logic [OUT_TDW-1:0]            m_axis_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int DIFW  = CW + 1;
    localparam int PRODW = 2 * DIFW;
    localparam int SUMW  = PRODW + 1;
    localparam int DW    = SUMW - 1;
    localparam int MW    = CW;
    localparam int NW    = DW + MW;
    localparam int QW    = CW;
    localparam int TAGW  = IW + 2;

    // Configuration registers
    logic signed [CW-1:0] r_start_x, r_start_y, r_goal_x, r_goal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sif_pkg::REG_START_X: r_start_x <= i_cfg_wdata;
                sif_pkg::REG_START_Y: r_start_y <= i_cfg_wdata;
                sif_pkg::REG_GOAL_X:  r_goal_x  <= i_cfg_wdata;
                sif_pkg::REG_GOAL_Y:  r_goal_y  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Query direction, magnitudes; user, not block, keeps them static while items are in flight
    logic signed [DIFW-1:0] s1x, s1y;
    logic [DIFW-1:0]        s1x_neg, s1y_neg;
    logic [MW-1:0]          s1x_mag, s1y_mag;

    always_comb begin
        s1x     = $signed({r_goal_x[CW-1], r_goal_x}) - $signed({r_start_x[CW-1], r_start_x});
        s1y     = $signed({r_goal_y[CW-1], r_goal_y}) - $signed({r_start_y[CW-1], r_start_y});
        s1x_neg = -s1x;
        s1y_neg = -s1y;
        s1x_mag = s1x[DIFW-1] ? s1x_neg[MW-1:0] : s1x[MW-1:0];
        s1y_mag = s1y[DIFW-1] ? s1y_neg[MW-1:0] : s1y[MW-1:0];
    end

    // Pipeline enable: hold the pipeline and the input once the skid entry is occupied
    logic r_skid_v;
    logic en;

    assign en            = !r_skid_v;
    assign s_axis_tready = en;

    // Stage 1: unpack and take differences
    logic [IW-1:0]        in_idx;
    logic signed [CW-1:0] p2x, p2y, p3x, p3y;

    assign in_idx = s_axis_tdata[IW-1:0];
    assign p2x    = s_axis_tdata[IW        +: CW];
    assign p2y    = s_axis_tdata[IW + CW   +: CW];
    assign p3x    = s_axis_tdata[IW + 2*CW +: CW];
    assign p3y    = s_axis_tdata[IW + 3*CW +: CW];

    logic                   r1_v;
    logic [IW-1:0]          r1_idx;
    logic signed [DIFW-1:0] r1_s2x, r1_s2y, r1_wx, r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
        end
        if (en) begin
            r1_idx <= in_idx;
            r1_s2x <= $signed({p3x[CW-1], p3x}) - $signed({p2x[CW-1], p2x});
            r1_s2y <= $signed({p3y[CW-1], p3y}) - $signed({p2y[CW-1], p2y});
            r1_wx  <= $signed({r_start_x[CW-1], r_start_x}) - $signed({p2x[CW-1], p2x});
            r1_wy  <= $signed({r_start_y[CW-1], r_start_y}) - $signed({p2y[CW-1], p2y});
        end
    end

    // Stage 2: the six cross products
    logic                    r2_v;
    logic [IW-1:0]           r2_idx;
    logic signed [PRODW-1:0] r2_da, r2_db, r2_sa, r2_sb, r2_ta, r2_tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_idx <= r1_idx;
            r2_da  <= PRODW'(s1x) * PRODW'(r1_s2y);
            r2_db  <= PRODW'(r1_s2x) * PRODW'(s1y);
            r2_sa  <= PRODW'(s1x) * PRODW'(r1_wy);
            r2_sb  <= PRODW'(s1y) * PRODW'(r1_wx);
            r2_ta  <= PRODW'(r1_s2x) * PRODW'(r1_wy);
            r2_tb  <= PRODW'(r1_s2y) * PRODW'(r1_wx);
        end
    end

    // Stage 3: denominator and numerators
    logic                   r3_v;
    logic [IW-1:0]          r3_idx;
    logic signed [SUMW-1:0] r3_d, r3_sn, r3_tn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_idx <= r2_idx;
            r3_d   <= {r2_da[PRODW-1], r2_da} - {r2_db[PRODW-1], r2_db};
            r3_sn  <= {r2_sa[PRODW-1], r2_sa} - {r2_sb[PRODW-1], r2_sb};
            r3_tn  <= {r2_ta[PRODW-1], r2_ta} - {r2_tb[PRODW-1], r2_tb};
        end
    end

    // Stage 4: fold the sign of d into the numerators and test both parameters
    logic [SUMW-1:0] d_a, sn_a, tn_a;
    logic            hit;

    always_comb begin
        d_a  = r3_d[SUMW-1] ? -r3_d  : r3_d;
        sn_a = r3_d[SUMW-1] ? -r3_sn : r3_sn;
        tn_a = r3_d[SUMW-1] ? -r3_tn : r3_tn;
        hit  = (r3_d != '0) && !sn_a[SUMW-1] && !tn_a[SUMW-1]
               && (sn_a <= d_a) && (tn_a <= d_a);
    end

    logic          r4_v;
    logic [IW-1:0] r4_idx;
    logic [DW-1:0] r4_d, r4_tn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v && hit;
        end
        if (en) begin
            r4_idx <= r3_idx;
            r4_d   <= d_a[DW-1:0];
            r4_tn  <= tn_a[DW-1:0];
        end
    end

    // Stage 5: scale the query direction by tn, as magnitudes
    logic          r5_v;
    logic [IW-1:0] r5_idx;
    logic          r5_sx, r5_sy;
    logic [DW-1:0] r5_d;
    logic [NW-1:0] r5_nx, r5_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
        if (en) begin
            r5_idx <= r4_idx;
            r5_sx  <= s1x[DIFW-1];
            r5_sy  <= s1y[DIFW-1];
            r5_d   <= r4_d;
            r5_nx  <= NW'(r4_tn) * NW'(s1x_mag);
            r5_ny  <= NW'(r4_tn) * NW'(s1y_mag);
        end
    end

    // Divide both products by |d|
    logic            dv_v;
    logic [QW-1:0]   dv_qx, dv_qy;
    logic [TAGW-1:0] dv_tag;

    sif_div_pipe #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (QW),
        .TAG_W (TAGW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_num_x (r5_nx),
        .i_num_y (r5_ny),
        .i_den   (r5_d),
        .i_tag   ({r5_sy, r5_sx, r5_idx}),
        .o_valid (dv_v),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_tag   (dv_tag)
    );

    // Restore signs, offset by the start point, drop hits with a zero offset from the start point
    logic [QW-1:0] qx_s, qy_s;
    logic [CW-1:0] res_x, res_y;
    logic [IW-1:0] res_idx;
    logic          res_v;

    always_comb begin
        qx_s    = dv_tag[IW]     ? -dv_qx : dv_qx;
        qy_s    = dv_tag[IW + 1] ? -dv_qy : dv_qy;
        res_x   = r_start_x + qx_s;
        res_y   = r_start_y + qy_s;
        res_idx = dv_tag[IW-1:0];
        res_v   = dv_v && ((dv_qx != '0) || (dv_qy != '0));
    end

    // Output register and skid entry
    logic          r_out_v, n_out_v, n_skid_v;
    logic [IW-1:0] r_out_idx, r_skid_idx;
    logic [CW-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic          push, load_from_skid, load_from_pipe, load_skid;

    always_comb begin
        push           = en && res_v;
        n_out_v        = r_out_v;
        n_skid_v       = r_skid_v;
        load_from_skid = 1'b0;
        load_from_pipe = 1'b0;
        load_skid      = 1'b0;
        if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                load_from_skid = 1'b1;
                n_out_v        = 1'b1;
                n_skid_v       = 1'b0;
            end else begin
                load_from_pipe = push;
                n_out_v        = push;
            end
        end else if (push) begin
            load_skid = 1'b1;
            n_skid_v  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        if (load_from_skid) begin
            r_out_idx <= r_skid_idx;
            r_out_x   <= r_skid_x;
            r_out_y   <= r_skid_y;
        end else if (load_from_pipe) begin
            r_out_idx <= res_idx;
            r_out_x   <= res_x;
            r_out_y   <= res_y;
        end
        if (load_skid) begin
            r_skid_idx <= res_idx;
            r_skid_x   <= res_x;
            r_skid_y   <= res_y;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDW'({r_out_y, r_out_x, r_out_idx});

endmodule

@@ design/sif_checker.sv @@
// Port-level checks for the segment intersection finder, bound to the top level.
`timescale 1ns / 1ps

module sif_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tready,
    input logic i_m_tvalid,
    input logic i_m_tready
);

    // Reset empties the pipeline and the output buffer
    a_reset_no_valid: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // Reset leaves the input side open
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_s_tready)
        else $error("input not ready right after reset");

    // Input backpressure only starts after a stalled result
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_s_tready) |-> $past(i_m_tvalid && !i_m_tready))
        else $error("input ready dropped without an output stall");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result withdrawn while stalled");

endmodule

bind segment_intersection_finder sif_checker u_sif_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready)
);
